>>> rtl/rolling_hash_substring_matcher_assert.svh
// Assertion macros for the checker file.
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_ASSERT_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_ASSERT_SVH

// Checked only while out of reset.
`define RHSM_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rhsm assertion failed");

// Checked at every edge, reset included.
`define RHSM_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("rhsm assertion failed");

`endif

>>> rtl/rhsm_pkg.sv
`timescale 1ns / 1ps

package rhsm_pkg;

    localparam int PATTERN_MAX    = 8;    // 1..8
    localparam int POSITION_WIDTH = 16;   // 8..32
    localparam int HASH_WIDTH     = 24;
    localparam int BYTE_WIDTH     = 8;
    localparam int PBYTES_WIDTH   = 64;
    localparam int PLEN_WIDTH     = 4;
    localparam int OUT_POS_WIDTH  = 16;
    localparam int COUNT_WIDTH    = 16;
    // 3^7 fits in 12 bits, enough for any length up to eight
    localparam int WEIGHT_WIDTH   = 12;
    localparam int TERM_WIDTH     = BYTE_WIDTH + WEIGHT_WIDTH;
    localparam int LEN_WIDTH      = $clog2(PATTERN_MAX + 1);
    localparam int PBYTE_IDX_W    = 3;    // byte select within pattern_bytes

    localparam logic [COUNT_WIDTH-1:0]    COUNT_MAX = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_MAX   = '1;

    typedef enum logic [0:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    // per-cell compare result and hash contributions
    typedef struct packed {
        logic                  eq;
        logic [TERM_WIDTH-1:0] win_term;
        logic [TERM_WIDTH-1:0] pat_term;
    } cell_res_t;

    function automatic logic [WEIGHT_WIDTH-1:0] pow3(input int n);
        logic [WEIGHT_WIDTH-1:0] w;
        w = WEIGHT_WIDTH'(1);
        for (int k = 0; k < n; k++) begin
            w = WEIGHT_WIDTH'(w * WEIGHT_WIDTH'(3));
        end
        return w;
    endfunction

endpackage

>>> rtl/rhsm_cell.sv
`timescale 1ns / 1ps

module rhsm_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             shift_en,
    input  logic                             clear,
    input  logic                             active,
    input  logic [rhsm_pkg::BYTE_WIDTH-1:0]  byte_in,
    input  logic [rhsm_pkg::BYTE_WIDTH-1:0]  pattern_byte,
    input  logic [rhsm_pkg::WEIGHT_WIDTH-1:0] weight,
    output logic [rhsm_pkg::BYTE_WIDTH-1:0]  byte_out,
    output rhsm_pkg::cell_res_t              res
);
    import rhsm_pkg::*;

    logic [BYTE_WIDTH-1:0] byte_reg;
    logic [BYTE_WIDTH-1:0] byte_next;

    // byte_in is the value this cell holds once the word is taken, or zero on clear
    always_comb begin
        byte_next = byte_reg;
        if (shift_en) begin
            byte_next = clear ? '0 : byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

    // operands widened first so the product keeps all its bits
    always_comb begin
        res.eq       = !active || (byte_in == pattern_byte);
        res.win_term = active ? TERM_WIDTH'(byte_in) * TERM_WIDTH'(weight) : '0;
        res.pat_term = active ? TERM_WIDTH'(pattern_byte) * TERM_WIDTH'(weight) : '0;
    end

endmodule

>>> rtl/rolling_hash_substring_matcher.sv
`timescale 1ns / 1ps
// Channel | Dir | Fields (low bit up)                         | Handshake
// s_      | in  | tdata: text_byte; tlast: text_last          | s_tvalid/s_tready
// m_      | out | tdata: match_position, match_count;         | m_tvalid/m_tready
//         |     | tuser: match_found; tlast: text_done        |
// cfg_    | in  | index 0 pattern_bytes, 1 pattern_length     | cfg_we
//
// One word per cycle while s_tready is high; a word's result shows the cycle after.
// The window compare and both hashes settle in the cycle of acceptance and
// land in a single output register.
// s_tready is high while that register is empty or being drained this cycle.
// Reset (synchronous, active low) resets window, counters, config and valid.

module rolling_hash_substring_matcher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // text_byte
    input  logic                                s_tlast,   // text_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,   // match_position, match_count
    output logic                                m_tuser,   // match_found
    output logic                                m_tlast,   // text_done
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [rhsm_pkg::PBYTES_WIDTH-1:0]   cfg_wdata
);
    import rhsm_pkg::*;

    // configuration
    logic [PBYTES_WIDTH-1:0] pat_bytes_reg;
    logic [PLEN_WIDTH-1:0]   pat_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= PLEN_WIDTH'(1);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:  pat_bytes_reg <= cfg_wdata;
                REG_PATTERN_LENGTH: pat_len_reg   <= cfg_wdata[PLEN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, anything above the window depth as the depth
    logic [LEN_WIDTH-1:0] len_used;
    always_comb begin
        priority if (pat_len_reg == '0) begin
            len_used = LEN_WIDTH'(1);
        end else if (pat_len_reg > PLEN_WIDTH'(PATTERN_MAX)) begin
            len_used = LEN_WIDTH'(PATTERN_MAX);
        end else begin
            len_used = LEN_WIDTH'(pat_len_reg);
        end
    end

    // handshake
    logic m_valid_reg, m_valid_next;
    logic s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // window: cell 0 holds the newest byte, weight 3^i
    logic [BYTE_WIDTH-1:0] cell_byte [PATTERN_MAX];
    cell_res_t             cell_res  [PATTERN_MAX];

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic [PBYTE_IDX_W-1:0] pidx;
        logic [BYTE_WIDTH-1:0]  chain_in;
        logic                   act;

        // cell i lines up with pattern byte len-1-i
        assign act   = LEN_WIDTH'(i) < len_used;
        assign pidx  = PBYTE_IDX_W'(len_used - LEN_WIDTH'(1) - LEN_WIDTH'(i));
        if (i == 0) begin : g_head
            assign chain_in = s_tdata;
        end else begin : g_body
            assign chain_in = cell_byte[i-1];
        end

        rhsm_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .shift_en     (s_accept),
            .clear        (s_tlast),
            .active       (act),
            .byte_in      (chain_in),
            .pattern_byte (pat_bytes_reg[BYTE_WIDTH*32'(pidx) +: BYTE_WIDTH]),
            .weight       (pow3(i)),
            .byte_out     (cell_byte[i]),
            .res          (cell_res[i])
        );
    end

    // hash sums and full compare
    logic [HASH_WIDTH-1:0] win_hash, pat_hash;
    logic                  all_eq;

    always_comb begin
        win_hash = '0;
        pat_hash = '0;
        all_eq   = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            win_hash = win_hash + HASH_WIDTH'(cell_res[i].win_term);
            pat_hash = pat_hash + HASH_WIDTH'(cell_res[i].pat_term);
            all_eq   = all_eq && cell_res[i].eq;
        end
    end

    // position and count
    logic [POSITION_WIDTH-1:0] idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0]    hits_reg, hits_next;
    logic                      found;
    logic [POSITION_WIDTH-1:0] pos;
    logic [COUNT_WIDTH-1:0]    hits_new;

    assign found = (idx_reg >= POSITION_WIDTH'(len_used - LEN_WIDTH'(1)))
                   && (win_hash == pat_hash) && all_eq;

    always_comb begin
        pos = '0;
        if (found) begin
            pos = (idx_reg == POS_MAX) ? POS_MAX
                : idx_reg - POSITION_WIDTH'(len_used - LEN_WIDTH'(1));
        end
        hits_new = hits_reg;
        if (found && hits_reg != COUNT_MAX) begin
            hits_new = hits_reg + COUNT_WIDTH'(1);
        end
    end

    always_comb begin
        idx_next  = idx_reg;
        hits_next = hits_reg;
        if (s_accept) begin
            if (s_tlast) begin
                idx_next  = '0;
                hits_next = '0;
            end else begin
                hits_next = hits_new;
                if (idx_reg != POS_MAX) begin
                    idx_next = idx_reg + POSITION_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            hits_reg <= '0;
        end else begin
            idx_reg  <= idx_next;
            hits_reg <= hits_next;
        end
    end

    // output register
    logic                     found_reg;
    logic [OUT_POS_WIDTH-1:0] pos_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic                     done_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            found_reg <= found;
            pos_reg   <= OUT_POS_WIDTH'(pos);
            count_reg <= hits_new;
            done_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {count_reg, pos_reg};
    assign m_tuser  = found_reg;
    assign m_tlast  = done_reg;

endmodule

>>> rtl/rhsm_checker.sv
`timescale 1ns / 1ps
`include "rolling_hash_substring_matcher_assert.svh"

module rhsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // a stalled word stays put
    `RHSM_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `RHSM_ASSERT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))
    // no result word straight after reset
    `RHSM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    // input side never blocked while the output register is free
    `RHSM_ASSERT(a_ready_free, aclk, aresetn, !m_tvalid |-> s_tready)
    // position only reported on a match
    `RHSM_ASSERT(a_pos_zero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[15:0] == 16'd0)

endmodule

bind rolling_hash_substring_matcher rhsm_checker u_rhsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb_rolling_hash_substring_matcher.sv
`timescale 1ns / 1ps

module tb_rolling_hash_substring_matcher;
    import rhsm_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_TEXT   = 40;     // one text of overlapping back-to-back matches
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 40;     // keeps a badly broken run's log readable

    // one text word as the sender offers it
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_word_t;

    // one result word as it should come back
    typedef struct packed {
        logic                     found;
        logic [OUT_POS_WIDTH-1:0] position;
        logic [COUNT_WIDTH-1:0]   count;
        logic                     done;
    } match_result_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata   = '0;
    logic                    s_tlast   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [31:0]             m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    cfg_we    = 1'b0;
    logic [0:0]              cfg_index = REG_PATTERN_BYTES;
    logic [PBYTES_WIDTH-1:0] cfg_wdata = '0;

    rolling_hash_substring_matcher DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the registers and the window
    // ---------------------------------------------------------------
    logic [PBYTES_WIDTH-1:0]   cfg_pattern = '0;
    logic [PLEN_WIDTH-1:0]     cfg_len_raw = PLEN_WIDTH'(1);
    logic [7:0]                win_bytes [PATTERN_MAX] = '{default: '0};  // [0] newest
    logic [POSITION_WIDTH-1:0] text_pos    = '0;
    logic [COUNT_WIDTH-1:0]    hit_count   = '0;

    // stimulus and bookkeeping
    text_word_t    text_words [$];
    match_result_t pending_results [$];
    text_word_t    next_word;
    match_result_t want;
    int unsigned   words_queued   = 0;
    int unsigned   words_taken    = 0;
    int unsigned   results_seen   = 0;
    int unsigned   matches_seen   = 0;
    int unsigned   texts_seen     = 0;
    int unsigned   mismatches     = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_idle_pct  = 0;
    int unsigned   hold_asked     = 0;
    int unsigned   hold_taken     = 0;
    int unsigned   hold_left      = 0;
    int unsigned   cycle_count;

    // zero counts as one, anything past the maximum as the maximum
    function automatic int unsigned effective_length(logic [PLEN_WIDTH-1:0] raw);
        if (raw == 0) return 1;
        if (raw > PATTERN_MAX) return PATTERN_MAX;
        return raw;
    endfunction

    // Shift the byte in and decide the match. Equal hashes only gate the
    // full byte compare, so the compare alone settles the answer.
    function automatic match_result_t next_match_result(logic [7:0] b, logic last);
        match_result_t r;
        int unsigned   len;
        logic          hit;
        len = effective_length(cfg_len_raw);
        for (int k = PATTERN_MAX - 1; k > 0; k--) win_bytes[k] = win_bytes[k - 1];
        win_bytes[0] = b;
        hit = (text_pos >= len - 1);  // short text: not enough bytes yet
        for (int k = 0; k < len; k++) begin
            if (win_bytes[len - 1 - k] != cfg_pattern[8 * k +: 8]) hit = 1'b0;
        end
        r.found    = hit;
        r.position = '0;
        if (hit) begin
            // stuck position reports the ceiling itself
            r.position = (text_pos == POS_MAX) ? OUT_POS_WIDTH'(POS_MAX)
                                               : OUT_POS_WIDTH'(text_pos - (len - 1));
            if (hit_count != COUNT_MAX) hit_count++;
        end
        r.count = hit_count;
        r.done  = last;
        if (last) begin
            win_bytes = '{default: '0};
            text_pos  = '0;
            hit_count = '0;
        end else if (text_pos != POS_MAX) begin
            text_pos++;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_val);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: result %0d, %s: got %0h, expected %0h",
                     $realtime, results_seen, what, got, exp_val);
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued text words, idling at random
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(next_match_result(s_tdata, s_tlast));
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (text_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = text_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.text_byte;
                    s_tlast  <= next_word.text_last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Hold-off counter: a long output stall when asked
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each taken result word against the oldest one due
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("word with none due", m_tdata, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.found)
                        report_mismatch("match_found", m_tuser, want.found);
                    if (m_tdata[15:0] !== want.position)
                        report_mismatch("match_position", m_tdata[15:0], want.position);
                    if (m_tdata[31:16] !== want.count)
                        report_mismatch("match_count", m_tdata[31:16], want.count);
                    if (m_tlast !== want.done)
                        report_mismatch("text_done", m_tlast, want.done);
                    matches_seen += want.found;
                    texts_seen   += want.done;
                end
                results_seen++;
            end
            // long hold-off when asked, else random back-pressure
            if (hold_left != 0 || hold_taken != hold_asked) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_text(logic [7:0] b, logic last);
        text_words.push_back('{text_byte: b, text_last: last});
        words_queued++;
    endtask

    // idle = every word taken and every result back
    task automatic wait_idle();
        while (words_taken != words_queued || pending_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [PBYTES_WIDTH-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_PATTERN_BYTES)
            cfg_pattern = value;
        else
            cfg_len_raw = value[PLEN_WIDTH-1:0];
    endtask

    // Texts built mostly from pattern copies and pattern bytes so hits are
    // common and overlap; the rest is noise. Some texts stay open across a
    // register change. A hold-off segment is long enough to back the block up.
    task automatic random_texts(int unsigned n_words, bit ask_hold);
        int unsigned sent;
        int unsigned run;
        int unsigned plen;
        int unsigned pick;
        logic [63:0] pat;
        logic [7:0]  letters [2];
        logic [7:0]  seg [$];
        bit          first;
        sent  = 0;
        first = 1'b1;
        while (sent < n_words) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                pat = '0;
            end else if (pick == 1) begin
                pat = '1;
            end else if (pick < 4) begin
                pat = {$urandom, $urandom};
            end else begin
                letters[0] = 8'($urandom);
                letters[1] = 8'($urandom);
                for (int k = 0; k < 8; k++) pat[8 * k +: 8] = letters[$urandom_range(1)];
            end
            write_reg(REG_PATTERN_BYTES, pat);
            if ($urandom_range(3) != 0)
                write_reg(REG_PATTERN_LENGTH, {$urandom, 28'($urandom),
                          ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(1, 8))});
            plen = effective_length(cfg_len_raw);
            run  = (ask_hold && first) ? 40 : $urandom_range(1, 48);
            seg.delete();
            while (seg.size() < run) begin
                pick = $urandom_range(19);
                if (pick < 3) begin
                    seg.push_back(8'($urandom));
                end else if (pick < 10) begin
                    for (int k = 0; k < plen; k++) seg.push_back(cfg_pattern[8 * k +: 8]);
                end else begin
                    seg.push_back(cfg_pattern[8 * $urandom_range(plen - 1) +: 8]);
                end
            end
            foreach (seg[i])
                push_text(seg[i], (i == seg.size() - 1) && ($urandom_range(4) != 0));
            sent += seg.size();
            if (ask_hold && first) hold_asked++;
            first = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Run-time guard
    // ---------------------------------------------------------------
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("[rolling_hash_substring_matcher] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 34;
        recv_idle_pct = 59;

        // length zero acts as one; zero pattern at both byte extremes
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        push_text(8'h00, 1'b1);

        // length above the maximum acts as eight: full-width pattern
        write_reg(REG_PATTERN_BYTES, 64'h0807_0605_0403_0201);
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        for (int k = 1; k <= 8; k++) push_text(8'(k), k == 8);

        // text ends before the pattern could fit
        write_reg(REG_PATTERN_LENGTH, 64'd4);
        push_text(8'h01, 1'b0);
        push_text(8'h02, 1'b0);
        push_text(8'h03, 1'b1);

        // equal hashes, different bytes: 01 00 and 00 03 both hash to 3
        write_reg(REG_PATTERN_BYTES, 64'h0001);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        push_text(8'h00, 1'b0);
        push_text(8'h03, 1'b1);

        // zero pattern against a cleared window: short text must not hit
        write_reg(REG_PATTERN_BYTES, 64'h0);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        push_text(8'h00, 1'b0);
        push_text(8'h00, 1'b1);
        for (int k = 0; k < 3; k++) push_text(8'h00, 1'b0);
        // length change mid-text; held window compared against it
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b1);

        random_texts(200, 1'b0);
        random_texts(200, 1'b1);

        send_idle_pct = 59;
        recv_idle_pct = 34;
        random_texts(200, 1'b0);
        random_texts(200, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_texts(400, 1'b0);

        // close any open text, then one text of overlapping matches on
        // every byte after the first
        push_text(8'h00, 1'b1);
        write_reg(REG_PATTERN_BYTES, 64'h5A5A);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        for (int k = 0; k < LONG_TEXT; k++) push_text(8'h5A, k == LONG_TEXT - 1);
        // counters must be back at zero for the next text
        push_text(8'h5A, 1'b0);
        push_text(8'h5A, 1'b1);

        wait_idle();
        repeat (8) @(posedge aclk);

        $display("run: %0d text words, %0d results, %0d matches over %0d texts",
                 words_taken, results_seen, matches_seen, texts_seen);
        $display("incl. idle/stall mixes, long output hold-offs, one %0d-byte text",
                 LONG_TEXT);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[rolling_hash_substring_matcher] OK");
        end else begin
            $display("[rolling_hash_substring_matcher] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/rhsm_pkg.sv
rtl/rhsm_cell.sv
rtl/rolling_hash_substring_matcher.sv
rtl/rhsm_checker.sv
test/tb_rolling_hash_substring_matcher.sv
